// ----- sv/iscr_pkg.sv -----
// shared constants, config register indexes and control structs
// for the int8 channel scale requantizer; no dependencies
package iscr_pkg;

	// fixed field widths
	localparam int unsigned DATA_W     = 8;
	localparam int unsigned RATIO_W    = 31;
	localparam int unsigned RATIO_FRAC = 24;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = RATIO_W;

	// default fraction bits of the channel scale
	localparam int unsigned FRAC_BITS_DEF = 13;

	// register reset values
	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(32'h0100_0000);

	// config register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RATIO     = 2'd0,
		CFG_EXC_ZERO  = 2'd1,
		CFG_FEAT_ZERO = 2'd2,
		CFG_OUT_ZERO  = 2'd3
	} cfg_idx_t;

	// item function codes
	localparam logic FUNC_EXC  = 1'b0;
	localparam logic FUNC_FEAT = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic exc_mul;
		logic exc_rnd;
		logic ofs_mul;
		logic ofs_fin;
		logic feat_mul;
		logic out_load;
	} iscr_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
	} iscr_sts_t;

endpackage

// ----- sv/iscr_in_if.sv -----
// input item channel: valid/ready with func and value
// depends on iscr_pkg
interface iscr_in_if import iscr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     func;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

// ----- sv/iscr_out_if.sv -----
// result item channel: valid/ready with the saturated int8 result
// depends on iscr_pkg
interface iscr_out_if import iscr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);
endinterface

// ----- sv/iscr_ctrl.sv -----
// sequencing state machine: accepts one item, then steps the datapath
// through the excitation or feature operations; depends on iscr_pkg
module iscr_ctrl import iscr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_func,
	output logic      in_ready,
	input  iscr_sts_t sts,
	output iscr_cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_EXC_MUL  = 7'b0000010,
		ST_EXC_RND  = 7'b0000100,
		ST_OFS_MUL  = 7'b0001000,
		ST_OFS_FIN  = 7'b0010000,
		ST_FEAT_MUL = 7'b0100000,
		ST_FEAT_OUT = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_func == FUNC_EXC) ? ST_EXC_MUL : ST_FEAT_MUL;
				end
			end
			ST_EXC_MUL:  state_d = ST_EXC_RND;
			ST_EXC_RND:  state_d = ST_OFS_MUL;
			ST_OFS_MUL:  state_d = ST_OFS_FIN;
			ST_OFS_FIN:  state_d = ST_IDLE;
			ST_FEAT_MUL: state_d = ST_FEAT_OUT;
			ST_FEAT_OUT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath commands
	always_comb begin
		cmd          = '0;
		cmd.load_in  = accept;
		cmd.exc_mul  = (state_q == ST_EXC_MUL);
		cmd.exc_rnd  = (state_q == ST_EXC_RND);
		cmd.ofs_mul  = (state_q == ST_OFS_MUL);
		cmd.ofs_fin  = (state_q == ST_OFS_FIN);
		cmd.feat_mul = (state_q == ST_FEAT_MUL);
		cmd.out_load = (state_q == ST_FEAT_OUT) && sts.out_free;
	end

endmodule

// ----- sv/iscr_dp.sv -----
// datapath: config registers, channel scale and offset, feature multiply,
// saturation and the output register; depends on iscr_pkg
module iscr_dp import iscr_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  logic signed [DATA_W-1:0] in_value,
	input  iscr_cmd_t                cmd,
	output iscr_sts_t                sts,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] out_result
);

	localparam int unsigned SHR      = RATIO_FRAC - FRAC_BITS;
	localparam int unsigned D_W      = DATA_W + 1;
	localparam int unsigned PROD_W   = D_W + RATIO_W + 1;
	localparam int unsigned N_W      = PROD_W + 1;
	localparam int unsigned SCALE_W  = N_W - SHR;
	localparam int unsigned MUL_W    = DATA_W + SCALE_W;
	localparam int unsigned MSH_W    = MUL_W - FRAC_BITS;
	localparam int unsigned OFS_W    = MSH_W + 1;
	localparam int unsigned SUM_W    = OFS_W + 1;
	localparam logic [N_W-1:0] RND_HALF = N_W'(1) << (SHR - 1);
	localparam logic [N_W-1:0] RND_MASK = (N_W'(1) << SHR) - N_W'(1);

	// config registers
	logic [RATIO_W-1:0]       ratio_q;
	logic signed [DATA_W-1:0] exc_zero_q;
	logic signed [DATA_W-1:0] feat_zero_q;
	logic signed [DATA_W-1:0] out_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q     <= RATIO_RESET;
			exc_zero_q  <= '0;
			feat_zero_q <= '0;
			out_zero_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_RATIO:     ratio_q     <= cfg_wdata[RATIO_W-1:0];
				CFG_EXC_ZERO:  exc_zero_q  <= cfg_wdata[DATA_W-1:0];
				CFG_FEAT_ZERO: feat_zero_q <= cfg_wdata[DATA_W-1:0];
				CFG_OUT_ZERO:  out_zero_q  <= cfg_wdata[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	// input value holding register
	logic signed [DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			value_q <= in_value;
		end
	end

	// excitation: (value - exc_zero) * ratio
	logic signed [D_W-1:0]     exc_d;
	logic signed [RATIO_W:0]   ratio_s;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [PROD_W-1:0]  prod_q;

	assign exc_d   = {value_q[DATA_W-1], value_q} - {exc_zero_q[DATA_W-1], exc_zero_q};
	assign ratio_s = {1'b0, ratio_q};
	assign prod_d  = PROD_W'(exc_d) * PROD_W'(ratio_s);

	always_ff @(posedge clk) begin
		if (cmd.exc_mul) begin
			prod_q <= prod_d;
		end
	end

	// round: add half, then shift truncating toward zero
	logic [N_W-1:0] rnd_n;
	logic [N_W-1:0] rnd_adj;

	assign rnd_n   = {prod_q[PROD_W-1], prod_q} + RND_HALF;
	assign rnd_adj = rnd_n + (rnd_n[N_W-1] ? RND_MASK : '0);

	// channel scale and offset state
	logic signed [SCALE_W-1:0] scale_q;
	logic signed [OFS_W-1:0]   offset_q;
	logic signed [MUL_W-1:0]   ofs_prod_d;
	logic signed [MUL_W-1:0]   ofs_prod_q;
	logic signed [MSH_W-1:0]   ofs_shr;
	logic signed [OFS_W-1:0]   offset_d;

	assign ofs_prod_d = MUL_W'(feat_zero_q) * MUL_W'(scale_q);
	assign ofs_shr    = ofs_prod_q[MUL_W-1:FRAC_BITS];
	assign offset_d   = OFS_W'(out_zero_q) - OFS_W'(ofs_shr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= '0;
			offset_q <= '0;
		end else begin
			if (cmd.exc_rnd) begin
				scale_q <= rnd_adj[N_W-1:SHR];
			end
			if (cmd.ofs_fin) begin
				offset_q <= offset_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ofs_mul) begin
			ofs_prod_q <= ofs_prod_d;
		end
	end

	// feature multiply
	logic signed [MUL_W-1:0] feat_prod_d;
	logic signed [MUL_W-1:0] feat_prod_q;

	assign feat_prod_d = MUL_W'(value_q) * MUL_W'(scale_q);

	always_ff @(posedge clk) begin
		if (cmd.feat_mul) begin
			feat_prod_q <= feat_prod_d;
		end
	end

	// floor shift, add offset, saturate
	logic signed [SUM_W-1:0]  sum;
	logic                     sat_hi;
	logic                     sat_lo;
	logic signed [DATA_W-1:0] sat_d;

	assign sum    = SUM_W'($signed(feat_prod_q[MUL_W-1:FRAC_BITS])) + SUM_W'(offset_q);
	assign sat_hi = !sum[SUM_W-1] && (sum[SUM_W-2:DATA_W-1] != '0);
	assign sat_lo = sum[SUM_W-1] && (sum[SUM_W-2:DATA_W-1] != '1);

	always_comb begin
		if (sat_hi) begin
			sat_d = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (sat_lo) begin
			sat_d = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat_d = sum[DATA_W-1:0];
		end
	end

	// output register
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_result_q <= sat_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_result   = out_result_q;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

// ----- sv/int8_channel_scale_requant_top.sv -----
// top level of the int8 channel scale requantizer
// depends on iscr_pkg, iscr_in_if, iscr_out_if, iscr_ctrl, iscr_dp
//
// Channels: feed (sink) takes items of func and value; func 0 is an
// excitation value that starts a channel and gives no result, func 1 is a
// feature element that gives one saturated int8 result on product (source).
// Config: cfg_wr_en/cfg_index/cfg_wdata write ratio_q24, exc_zero,
// feat_zero and out_zero; write only while no item is in flight.
// Sequence: one item at a time. An excitation item steps through accept,
// scale multiply, rounding, offset multiply and offset subtract. A feature
// item steps through accept, multiply and shift/add/saturate into the output
// register; the next item is taken only once the sequencer is back in idle,
// since the sequencer steps the shared datapath registers.
// Stall: the result sits in the output register; the next item is accepted
// while it waits, and a feature stalls in its last step until the output
// register frees up. Nothing is dropped.
// Reset: arst_n clears the sequencer, the output valid, the channel scale
// and offset (features before any excitation give 0) and loads the
// register defaults.
module int8_channel_scale_requant_top import iscr_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	iscr_in_if.sink               feed,
	iscr_out_if.source            product
);

	iscr_cmd_t cmd;
	iscr_sts_t sts;

	// sequencer
	iscr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (feed.valid),
		.in_func  (feed.func),
		.in_ready (feed.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic and registers
	iscr_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_value   (feed.value),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (product.valid),
		.out_ready  (product.ready),
		.out_result (product.result)
	);

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the int8 channel scale requantizer
// depends on iscr_pkg, iscr_in_if, iscr_out_if and int8_channel_scale_requant_top
// directed table first, then random channels under several register settings
module testbench;
	import iscr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_HALF      = 6;
	localparam int          RESET_CYCLES  = 11;
	localparam int          SCALE_SHIFT   = RATIO_FRAC - FRAC_BITS_DEF;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          ITEMS_PER_SET = 95;
	localparam int          RAND_SETS     = 4;
	localparam int          DIR_ROWS      = 30;
	localparam longint      CYCLE_LIMIT   = 200000;
	localparam logic signed [DATA_W-1:0] S8_MAX = 8'sd127;
	localparam logic signed [DATA_W-1:0] S8_MIN = -8'sd128;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	// one line of directed stimulus: an item or a register write
	typedef struct packed {
		row_kind_t                kind;
		logic                     func;
		logic signed [DATA_W-1:0] value;
		logic                     typed;
		logic signed [DATA_W-1:0] want;
		cfg_idx_t                 idx;
		logic [CFG_DATA_W-1:0]    data;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	iscr_in_if  feed_if ();
	iscr_out_if product_if ();

	int8_channel_scale_requant_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.feed      (feed_if),
		.product   (product_if)
	);

	// predictor state
	longint m_ratio;
	longint m_exc_zero;
	longint m_feat_zero;
	longint m_out_zero;
	longint m_scale;
	longint m_offset;

	// scoreboard and counters
	logic signed [DATA_W-1:0] exp_q [$];
	int     err_count    = 0;
	int     items_sent   = 0;
	int     exc_sent     = 0;
	int     results_seen = 0;
	int     reg_writes   = 0;
	int     pauses       = 0;
	longint cycle_count  = 0;

	stim_row_t dir_rows [DIR_ROWS];

	// clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// predictor
	function automatic void model_reset();
		m_ratio     = longint'(RATIO_RESET);
		m_exc_zero  = 0;
		m_feat_zero = 0;
		m_out_zero  = 0;
		m_scale     = 0;
		m_offset    = 0;
	endfunction

	function automatic void model_config(input cfg_idx_t idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_RATIO:     m_ratio     = longint'(data[RATIO_W-1:0]);
			CFG_EXC_ZERO:  m_exc_zero  = longint'($signed(data[DATA_W-1:0]));
			CFG_FEAT_ZERO: m_feat_zero = longint'($signed(data[DATA_W-1:0]));
			CFG_OUT_ZERO:  m_out_zero  = longint'($signed(data[DATA_W-1:0]));
			default: ;
		endcase
	endfunction

	function automatic bit model_step(input logic func, input logic signed [DATA_W-1:0] value,
			output logic signed [DATA_W-1:0] res);
		longint v;
		longint d;
		longint p;
		longint n;
		longint r;
		v   = longint'(value);
		res = '0;
		if (func == FUNC_EXC) begin
			d = v - m_exc_zero;
			p = d * m_ratio;
			n = p + (longint'(1) <<< (SCALE_SHIFT - 1));
			if (n < 0) begin
				m_scale = -((-n) >>> SCALE_SHIFT);
			end else begin
				m_scale = n >>> SCALE_SHIFT;
			end
			m_offset = m_out_zero - ((m_feat_zero * m_scale) >>> FRAC_BITS_DEF);
			return 1'b0;
		end
		r = ((v * m_scale) >>> FRAC_BITS_DEF) + m_offset;
		if (r < longint'(S8_MIN)) begin
			r = longint'(S8_MIN);
		end
		if (r > longint'(S8_MAX)) begin
			r = longint'(S8_MAX);
		end
		res = r[DATA_W-1:0];
		return 1'b1;
	endfunction

	// table row builders
	function automatic stim_row_t item_row(input logic func, input logic signed [DATA_W-1:0] value,
			input logic typed, input logic signed [DATA_W-1:0] want);
		stim_row_t r;
		r       = '0;
		r.kind  = ROW_ITEM;
		r.func  = func;
		r.value = value;
		r.typed = typed;
		r.want  = want;
		r.idx   = CFG_RATIO;
		return r;
	endfunction

	function automatic stim_row_t reg_row(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r      = '0;
		r.kind = ROW_REG;
		r.idx  = idx;
		r.data = data;
		return r;
	endfunction

	// send one item after a random idle gap, predict at the accepting edge
	task automatic send_item(input logic func, input logic signed [DATA_W-1:0] value,
			input logic typed, input logic signed [DATA_W-1:0] want);
		int unsigned              gap;
		logic signed [DATA_W-1:0] pred;
		bit                       has_res;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			feed_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feed_if.valid <= 1'b1;
		feed_if.func  <= func;
		feed_if.value <= value;
		do begin
			@(posedge clk);
		end while (!(feed_if.valid && feed_if.ready));
		has_res = model_step(func, value, pred);
		if (has_res) begin
			exp_q.push_back(typed ? want : pred);
		end
		items_sent++;
		if (func == FUNC_EXC) begin
			exc_sent++;
		end
	endtask

	// stop sending and wait until every expected result has come
	task automatic quiesce();
		feed_if.valid <= 1'b0;
		@(posedge clk);
		while (exp_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write, only while nothing is in flight
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		model_config(idx, data);
		reg_writes++;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// random item with some extreme values
	task automatic rand_item(output logic func, output logic signed [DATA_W-1:0] value);
		func = ($urandom_range(0, 7) == 0) ? FUNC_EXC : FUNC_FEAT;
		case ($urandom_range(0, 9))
			0:       value = S8_MIN;
			1:       value = S8_MAX;
			default: value = DATA_W'($urandom());
		endcase
	endtask

	// receiver with a random wait before each item
	initial begin : sink
		int unsigned gap;
		product_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = $urandom_range(0, 3);
			if (gap != 0) begin
				product_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			product_if.ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!(product_if.valid && product_if.ready));
		end
	end

	// result checker
	always @(posedge clk) begin : monitor
		logic signed [DATA_W-1:0] exp_v;
		if (product_if.valid && product_if.ready) begin
			if (exp_q.size() == 0) begin
				$error("result: unexpected item, actual %0d", product_if.result);
				err_count++;
			end else begin
				exp_v = exp_q.pop_front();
				if (product_if.result !== exp_v) begin
					$error("result mismatch: expected %0d, actual %0d", exp_v,
						product_if.result);
					err_count++;
				end
				results_seen++;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("cycle limit of %0d reached", CYCLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// stimulus
	initial begin : driver
		logic                     f;
		logic signed [DATA_W-1:0] v;
		logic [CFG_DATA_W-1:0]    ratio;

		// directed table
		dir_rows[0]  = item_row(FUNC_FEAT, 8'sd5, 1'b1, 8'sd0);
		dir_rows[1]  = item_row(FUNC_FEAT, -8'sd128, 1'b1, 8'sd0);
		dir_rows[2]  = item_row(FUNC_EXC, 8'sd127, 1'b0, 8'sd0);
		dir_rows[3]  = item_row(FUNC_FEAT, 8'sd127, 1'b1, 8'sd127);
		dir_rows[4]  = item_row(FUNC_FEAT, -8'sd128, 1'b1, -8'sd128);
		dir_rows[5]  = item_row(FUNC_EXC, 8'sd1, 1'b0, 8'sd0);
		dir_rows[6]  = item_row(FUNC_FEAT, -8'sd77, 1'b1, -8'sd77);
		dir_rows[7]  = item_row(FUNC_FEAT, 8'sd0, 1'b1, 8'sd0);
		dir_rows[8]  = reg_row(CFG_FEAT_ZERO, CFG_DATA_W'(10));
		dir_rows[9]  = reg_row(CFG_OUT_ZERO, CFG_DATA_W'(-20));
		dir_rows[10] = item_row(FUNC_FEAT, 8'sd50, 1'b0, 8'sd0);
		dir_rows[11] = item_row(FUNC_EXC, 8'sd3, 1'b0, 8'sd0);
		dir_rows[12] = item_row(FUNC_FEAT, 8'sd40, 1'b0, 8'sd0);
		dir_rows[13] = item_row(FUNC_FEAT, -8'sd128, 1'b0, 8'sd0);
		dir_rows[14] = reg_row(CFG_EXC_ZERO, CFG_DATA_W'(100));
		dir_rows[15] = reg_row(CFG_RATIO, {CFG_DATA_W{1'b1}});
		dir_rows[16] = item_row(FUNC_EXC, -8'sd128, 1'b0, 8'sd0);
		dir_rows[17] = item_row(FUNC_FEAT, 8'sd1, 1'b0, 8'sd0);
		dir_rows[18] = item_row(FUNC_FEAT, -8'sd1, 1'b0, 8'sd0);
		dir_rows[19] = item_row(FUNC_FEAT, 8'sd0, 1'b0, 8'sd0);
		dir_rows[20] = reg_row(CFG_RATIO, CFG_DATA_W'(12345678));
		dir_rows[21] = item_row(FUNC_EXC, -8'sd101, 1'b0, 8'sd0);
		dir_rows[22] = item_row(FUNC_FEAT, 8'sd77, 1'b0, 8'sd0);
		dir_rows[23] = item_row(FUNC_FEAT, -8'sd128, 1'b0, 8'sd0);
		dir_rows[24] = item_row(FUNC_EXC, 8'sd100, 1'b0, 8'sd0);
		dir_rows[25] = item_row(FUNC_FEAT, 8'sd127, 1'b0, 8'sd0);
		dir_rows[26] = reg_row(CFG_RATIO, RATIO_RESET);
		dir_rows[27] = reg_row(CFG_EXC_ZERO, '0);
		dir_rows[28] = reg_row(CFG_FEAT_ZERO, '0);
		dir_rows[29] = reg_row(CFG_OUT_ZERO, '0);

		// reset
		model_reset();
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= '0;
		cfg_wdata     <= '0;
		feed_if.valid <= 1'b0;
		feed_if.func  <= FUNC_EXC;
		feed_if.value <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_REG) begin
				quiesce();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_item(dir_rows[i].func, dir_rows[i].value, dir_rows[i].typed,
					dir_rows[i].want);
			end
		end

		// random channels under several register settings
		for (int s = 0; s < RAND_SETS; s++) begin
			quiesce();
			case (s)
				0:       ratio = RATIO_RESET;
				1:       ratio = CFG_DATA_W'($urandom_range(0, 32'h0400_0000));
				2:       ratio = {CFG_DATA_W{1'b1}};
				default: ratio = CFG_DATA_W'($urandom());
			endcase
			write_reg(CFG_RATIO, ratio);
			write_reg(CFG_EXC_ZERO, CFG_DATA_W'($urandom_range(0, 255)));
			write_reg(CFG_FEAT_ZERO, CFG_DATA_W'($urandom_range(0, 255)));
			write_reg(CFG_OUT_ZERO, CFG_DATA_W'($urandom_range(0, 255)));
			send_item(FUNC_EXC, DATA_W'($urandom()), 1'b0, '0);
			for (int k = 1; k < ITEMS_PER_SET; k++) begin
				// hold the sender until the block has drained
				if (s == 1 && k == ITEMS_PER_SET / 2) begin
					quiesce();
					pauses++;
				end
				rand_item(f, v);
				send_item(f, v, 1'b0, '0);
			end
		end

		quiesce();

		$display("sent %0d items (%0d excitations), checked %0d results", items_sent,
			exc_sent, results_seen);
		$display("%0d register writes, %0d drain pauses, random idle on both sides",
			reg_writes, pauses);
		if (err_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
